>>> rtl/core/bms_pkg.sv
// Shared types for the Boyer-Moore search block: payload structs and sequencer states.
package bms_pkg;

  localparam int unsigned SYMBOL_BITS = 8;
  localparam int unsigned ALPHABET = 256;
  localparam int unsigned RESULT_BITS = 32;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  typedef struct packed {
    logic                   op;
    logic [SYMBOL_BITS-1:0] symbol;
    logic                   last;
  } req_t;

  typedef struct packed {
    logic                   match_found;
    logic [RESULT_BITS-1:0] match_position;
    logic                   finished;
    logic [RESULT_BITS-1:0] match_count;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SUF_INIT,
    ST_SUF_TEST,
    ST_SUF_CHK,
    ST_SUF_ELSE,
    ST_CMP_A,
    ST_CMP_B,
    ST_CMP_CHK,
    ST_SUF_NEXT,
    ST_GS_FILL,
    ST_GS2_TEST,
    ST_GS2_CHK,
    ST_GS2_WR,
    ST_GS2_NEXT,
    ST_GS3_RD,
    ST_GS3_WR,
    ST_BC_FILL,
    ST_BC_RD,
    ST_BC_WR,
    ST_TX_RD,
    ST_TX_CHK,
    ST_TX_SHIFT,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/core/bms_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
module bms_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/boyer_moore_search.sv
// Boyer-Moore search top level: table builder, window compare and result register.
//
// Usage: send the pattern as op=0 items, one byte each, with last set on the final
// byte. Bytes past MAX_PATTERN are dropped. The final pattern byte starts a table
// build (suffix, good-suffix and bad-character tables) during which req_ready is low;
// the build walks over the table memories. Text then streams as op=1 items. Each byte
// is written into a ring of MAX_PATTERN bytes; once the window is full it is compared
// right to left, each byte read and then checked, and a shift step then moves the
// window. A response item appears when a window matches (with its start offset) and
// on the last text byte (finished set, with the total count, after which the count
// and text offset restart from zero). Results leave through a register; a stalled
// receiver holds the block in its emit step and blocks further items. Reset clears
// the sequencer, the lengths, the counters and the output valid; the table memories
// are not cleared, and text is ignored until a pattern is closed.
module boyer_moore_search #(
  parameter int unsigned MAX_PATTERN   = 256,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  bms_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output bms_pkg::rsp_t   rsp
);

  localparam int unsigned AW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LW   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned SW   = LW + 1;
  localparam int unsigned XW   = SW + 1;
  localparam int unsigned BW   = $clog2(bms_pkg::ALPHABET);
  localparam int unsigned SYMW = bms_pkg::SYMBOL_BITS;
  localparam int unsigned RW   = bms_pkg::RESULT_BITS;

  // Ring index: base plus an offset below MAX_PATTERN, folded once.
  function automatic logic [AW-1:0] wrap(input logic [LW:0] sum);
    logic [LW:0] folded;
    folded = (sum >= (LW+1)'(MAX_PATTERN)) ? sum - (LW+1)'(MAX_PATTERN) : sum;
    return folded[AW-1:0];
  endfunction

  bms_pkg::state_t state, state_next;

  logic [LW-1:0]           plen, plen_next;
  logic                    ready, ready_next;
  logic [LW-1:0]           fill, fill_next;
  logic [AW-1:0]           base, base_next;
  logic [POSITION_BITS-1:0] offset, offset_next;
  logic [RW-1:0]           total, total_next;
  logic signed [SW-1:0]    i_idx, i_next;
  logic signed [SW-1:0]    g_idx, g_next;
  logic signed [SW-1:0]    f_idx, f_next;
  logic [LW-1:0]           j_idx, j_next;
  logic [BW-1:0]           cnt, cnt_next;
  logic [SYMW-1:0]         p_hold, p_hold_next;
  logic                    found, found_next;
  logic                    is_last, is_last_next;
  logic [RW-1:0]           pos, pos_next;
  logic                    out_v, out_v_next;
  bms_pkg::rsp_t           out_r, out_r_next;

  logic            p_we, s_we, gs_we, bc_we, tw_we;
  logic [AW-1:0]   p_waddr, s_waddr, gs_waddr, tw_waddr;
  logic [AW-1:0]   p_raddr, s_raddr, gs_raddr, tw_raddr;
  logic [BW-1:0]   bc_waddr, bc_raddr;
  logic [SYMW-1:0] p_wdata, tw_wdata, p_rdata, tw_rdata;
  logic [LW-1:0]   s_wdata, gs_wdata, bc_wdata, s_rdata, gs_rdata, bc_rdata;

  bms_ram #(.DEPTH(MAX_PATTERN), .WIDTH(SYMW), .AW(AW)) u_pattern (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata));
  bms_ram #(.DEPTH(MAX_PATTERN), .WIDTH(LW), .AW(AW)) u_suffix (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));
  bms_ram #(.DEPTH(MAX_PATTERN), .WIDTH(LW), .AW(AW)) u_good (
    .clk, .we(gs_we), .waddr(gs_waddr), .wdata(gs_wdata), .raddr(gs_raddr),
    .rdata(gs_rdata));
  bms_ram #(.DEPTH(bms_pkg::ALPHABET), .WIDTH(LW), .AW(BW)) u_bad (
    .clk, .we(bc_we), .waddr(bc_waddr), .wdata(bc_wdata), .raddr(bc_raddr),
    .rdata(bc_rdata));
  bms_ram #(.DEPTH(MAX_PATTERN), .WIDTH(SYMW), .AW(AW)) u_window (
    .clk, .we(tw_we), .waddr(tw_waddr), .wdata(tw_wdata), .raddr(tw_raddr),
    .rdata(tw_rdata));

  logic signed [SW-1:0] m_s;
  logic [LW-1:0]        eff_len;
  logic [LW-1:0]        new_len;
  logic [LW-1:0]        fill_inc;
  logic signed [XW-1:0] bc_term, gs_term, shift_raw;
  logic [LW-1:0]        shift;

  assign m_s = $signed({1'b0, plen});
  assign eff_len = ready ? '0 : plen;
  assign new_len = (eff_len < LW'(MAX_PATTERN)) ? eff_len + LW'(1) : eff_len;
  assign fill_inc = fill + LW'(1);

  // Shift after a compare: whole-match good suffix, or the larger of both rules.
  always_comb begin
    gs_term = $signed({2'b00, gs_rdata});
    bc_term = $signed({2'b00, bc_rdata}) - XW'(m_s) + XW'(1) + XW'(i_idx);
    shift_raw = (!found && (bc_term > gs_term)) ? bc_term : gs_term;
    if (shift_raw < XW'(1)) begin
      shift = LW'(1);
    end else if (shift_raw > XW'(m_s)) begin
      shift = plen;
    end else begin
      shift = shift_raw[LW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bms_pkg::ST_IDLE;
      plen   <= '0;
      ready  <= 1'b0;
      fill   <= '0;
      base   <= '0;
      offset <= '0;
      total  <= '0;
      out_v  <= 1'b0;
    end else begin
      state  <= state_next;
      plen   <= plen_next;
      ready  <= ready_next;
      fill   <= fill_next;
      base   <= base_next;
      offset <= offset_next;
      total  <= total_next;
      out_v  <= out_v_next;
    end
  end

  always_ff @(posedge clk) begin
    i_idx   <= i_next;
    g_idx   <= g_next;
    f_idx   <= f_next;
    j_idx   <= j_next;
    cnt     <= cnt_next;
    p_hold  <= p_hold_next;
    found   <= found_next;
    is_last <= is_last_next;
    pos     <= pos_next;
    out_r   <= out_r_next;
  end

  always_comb begin
    state_next   = state;
    plen_next    = plen;
    ready_next   = ready;
    fill_next    = fill;
    base_next    = base;
    offset_next  = offset;
    total_next   = total;
    i_next       = i_idx;
    g_next       = g_idx;
    f_next       = f_idx;
    j_next       = j_idx;
    cnt_next     = cnt;
    p_hold_next  = p_hold;
    found_next   = found;
    is_last_next = is_last;
    pos_next     = pos;
    out_v_next   = out_v && !rsp_ready;
    out_r_next   = out_r;

    p_we = 1'b0;  p_waddr = eff_len[AW-1:0];  p_wdata = req.symbol;  p_raddr = '0;
    s_we = 1'b0;  s_waddr = '0;  s_wdata = '0;  s_raddr = '0;
    gs_we = 1'b0; gs_waddr = '0; gs_wdata = '0; gs_raddr = '0;
    bc_we = 1'b0; bc_waddr = '0; bc_wdata = '0; bc_raddr = '0;
    tw_we = 1'b0; tw_waddr = wrap({1'b0, fill} + (LW+1)'(base)); tw_wdata = req.symbol;
    tw_raddr = '0;

    req_ready = (state == bms_pkg::ST_IDLE);

    unique case (state)
      bms_pkg::ST_IDLE: begin
        if (req_valid) begin
          is_last_next = req.last;
          found_next   = 1'b0;
          pos_next     = '0;
          if (req.op == bms_pkg::OP_PATTERN) begin
            if (ready) begin
              ready_next  = 1'b0;
              fill_next   = '0;
              base_next   = '0;
              offset_next = '0;
              total_next  = '0;
            end
            p_we      = (eff_len < LW'(MAX_PATTERN));
            plen_next = new_len;
            if (req.last) begin
              ready_next  = 1'b1;
              fill_next   = '0;
              base_next   = '0;
              offset_next = '0;
              total_next  = '0;
              state_next  = bms_pkg::ST_SUF_INIT;
            end
          end else if (ready && plen != '0) begin
            tw_we     = 1'b1;
            fill_next = fill_inc;
            if (fill_inc >= plen) begin
              i_next     = m_s - SW'(1);
              state_next = bms_pkg::ST_TX_RD;
            end else if (req.last) begin
              state_next = bms_pkg::ST_EMIT;
            end
          end else if (req.last) begin
            state_next = bms_pkg::ST_EMIT;
          end
        end
      end

      bms_pkg::ST_SUF_INIT: begin
        s_we    = 1'b1;
        s_waddr = AW'(plen - LW'(1));
        s_wdata = plen;
        if (plen == LW'(1)) begin
          j_next     = '0;
          state_next = bms_pkg::ST_GS_FILL;
        end else begin
          i_next     = m_s - SW'(2);
          g_next     = m_s - SW'(1);
          f_next     = '0;
          state_next = bms_pkg::ST_SUF_TEST;
        end
      end

      bms_pkg::ST_SUF_TEST: begin
        s_raddr = AW'(i_idx + m_s - SW'(1) - f_idx);
        state_next = (i_idx > g_idx) ? bms_pkg::ST_SUF_CHK : bms_pkg::ST_SUF_ELSE;
      end

      bms_pkg::ST_SUF_CHK: begin
        if ($signed({1'b0, s_rdata}) < (i_idx - g_idx)) begin
          s_we       = 1'b1;
          s_waddr    = AW'(i_idx);
          s_wdata    = s_rdata;
          state_next = bms_pkg::ST_SUF_NEXT;
        end else begin
          state_next = bms_pkg::ST_SUF_ELSE;
        end
      end

      bms_pkg::ST_SUF_ELSE: begin
        if (i_idx < g_idx) begin
          g_next = i_idx;
        end
        f_next     = i_idx;
        state_next = bms_pkg::ST_CMP_A;
      end

      bms_pkg::ST_CMP_A: begin
        if (g_idx < 0) begin
          s_we       = 1'b1;
          s_waddr    = AW'(i_idx);
          s_wdata    = LW'(f_idx - g_idx);
          state_next = bms_pkg::ST_SUF_NEXT;
        end else begin
          p_raddr    = AW'(g_idx);
          state_next = bms_pkg::ST_CMP_B;
        end
      end

      bms_pkg::ST_CMP_B: begin
        p_hold_next = p_rdata;
        p_raddr     = AW'(g_idx + m_s - SW'(1) - f_idx);
        state_next  = bms_pkg::ST_CMP_CHK;
      end

      bms_pkg::ST_CMP_CHK: begin
        if (p_hold == p_rdata) begin
          g_next     = g_idx - SW'(1);
          state_next = bms_pkg::ST_CMP_A;
        end else begin
          s_we       = 1'b1;
          s_waddr    = AW'(i_idx);
          s_wdata    = LW'(f_idx - g_idx);
          state_next = bms_pkg::ST_SUF_NEXT;
        end
      end

      bms_pkg::ST_SUF_NEXT: begin
        if (i_idx == '0) begin
          j_next     = '0;
          state_next = bms_pkg::ST_GS_FILL;
        end else begin
          i_next     = i_idx - SW'(1);
          state_next = bms_pkg::ST_SUF_TEST;
        end
      end

      bms_pkg::ST_GS_FILL: begin
        gs_we    = 1'b1;
        gs_waddr = j_idx[AW-1:0];
        gs_wdata = plen;
        j_next   = j_idx + LW'(1);
        if (j_idx == plen - LW'(1)) begin
          i_next     = m_s - SW'(1);
          j_next     = '0;
          state_next = bms_pkg::ST_GS2_TEST;
        end
      end

      bms_pkg::ST_GS2_TEST: begin
        s_raddr    = AW'(i_idx);
        state_next = (i_idx < 0) ? bms_pkg::ST_GS2_WR : bms_pkg::ST_GS2_CHK;
      end

      bms_pkg::ST_GS2_CHK: begin
        state_next = ($signed({1'b0, s_rdata}) == i_idx + SW'(1)) ?
                     bms_pkg::ST_GS2_WR : bms_pkg::ST_GS2_NEXT;
      end

      // Every entry still holds the fill value here, since j only moves forward.
      bms_pkg::ST_GS2_WR: begin
        if ($signed({1'b0, j_idx}) < m_s - SW'(1) - i_idx) begin
          gs_we    = 1'b1;
          gs_waddr = j_idx[AW-1:0];
          gs_wdata = LW'(m_s - SW'(1) - i_idx);
          j_next   = j_idx + LW'(1);
        end else begin
          state_next = bms_pkg::ST_GS2_NEXT;
        end
      end

      bms_pkg::ST_GS2_NEXT: begin
        if (i_idx < 0) begin
          i_next     = '0;
          cnt_next   = '0;
          state_next = (plen == LW'(1)) ? bms_pkg::ST_BC_FILL : bms_pkg::ST_GS3_RD;
        end else begin
          i_next     = i_idx - SW'(1);
          state_next = bms_pkg::ST_GS2_TEST;
        end
      end

      bms_pkg::ST_GS3_RD: begin
        s_raddr    = AW'(i_idx);
        state_next = bms_pkg::ST_GS3_WR;
      end

      bms_pkg::ST_GS3_WR: begin
        gs_we    = 1'b1;
        gs_waddr = AW'(plen - LW'(1) - s_rdata);
        gs_wdata = LW'(m_s - SW'(1) - i_idx);
        if (i_idx == m_s - SW'(2)) begin
          cnt_next   = '0;
          state_next = bms_pkg::ST_BC_FILL;
        end else begin
          i_next     = i_idx + SW'(1);
          state_next = bms_pkg::ST_GS3_RD;
        end
      end

      bms_pkg::ST_BC_FILL: begin
        bc_we    = 1'b1;
        bc_waddr = cnt;
        bc_wdata = plen;
        cnt_next = cnt + BW'(1);
        if (cnt == BW'(bms_pkg::ALPHABET - 1)) begin
          i_next     = '0;
          state_next = bms_pkg::ST_BC_RD;
        end
      end

      bms_pkg::ST_BC_RD: begin
        p_raddr    = AW'(i_idx);
        state_next = bms_pkg::ST_BC_WR;
      end

      bms_pkg::ST_BC_WR: begin
        bc_we    = 1'b1;
        bc_waddr = p_rdata;
        bc_wdata = LW'(m_s - SW'(1) - i_idx);
        if (i_idx == m_s - SW'(1)) begin
          state_next = bms_pkg::ST_IDLE;
        end else begin
          i_next     = i_idx + SW'(1);
          state_next = bms_pkg::ST_BC_RD;
        end
      end

      bms_pkg::ST_TX_RD: begin
        p_raddr    = AW'(i_idx);
        tw_raddr   = wrap((LW+1)'(i_idx) + (LW+1)'(base));
        state_next = bms_pkg::ST_TX_CHK;
      end

      bms_pkg::ST_TX_CHK: begin
        if (p_rdata != tw_rdata) begin
          bc_raddr   = tw_rdata;
          gs_raddr   = AW'(i_idx);
          state_next = bms_pkg::ST_TX_SHIFT;
        end else if (i_idx == '0) begin
          found_next = 1'b1;
          pos_next   = RW'(offset);
          total_next = (total == '1) ? total : total + RW'(1);
          gs_raddr   = '0;
          state_next = bms_pkg::ST_TX_SHIFT;
        end else begin
          i_next     = i_idx - SW'(1);
          state_next = bms_pkg::ST_TX_RD;
        end
      end

      bms_pkg::ST_TX_SHIFT: begin
        fill_next   = fill - shift;
        base_next   = wrap((LW+1)'(base) + (LW+1)'(shift));
        offset_next = offset + POSITION_BITS'(shift);
        state_next  = (found || is_last) ? bms_pkg::ST_EMIT : bms_pkg::ST_IDLE;
      end

      bms_pkg::ST_EMIT: begin
        if (!out_v || rsp_ready) begin
          out_v_next                = 1'b1;
          out_r_next.match_found    = found;
          out_r_next.match_position = pos;
          out_r_next.finished       = is_last;
          out_r_next.match_count    = total;
          if (is_last) begin
            fill_next   = '0;
            base_next   = '0;
            offset_next = '0;
            total_next  = '0;
          end
          state_next = bms_pkg::ST_IDLE;
        end
      end

      default: state_next = bms_pkg::ST_IDLE;
    endcase
  end

  assign rsp_valid = out_v;
  assign rsp       = out_r;

endmodule

>>> rtl/core/bms_checker.sv
// Port-level checks for the Boyer-Moore search block, bound to the top level.
module bms_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input bms_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bms_pkg::rsp_t rsp
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  // A response without a match only comes from the last text byte.
  a_nomatch_final: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.match_found |-> rsp.finished)
    else $error("empty response not marked finished");

  a_nomatch_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.match_found |-> rsp.match_position == '0)
    else $error("position set without a match");

  // A match is always counted.
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.match_found |-> rsp.match_count != '0)
    else $error("match reported with zero count");

endmodule

bind boyer_moore_search bms_checker u_bms_checker (.*);
